[rtl/core/ccdcal_pkg.sv]
// Shared types and constants for the CCD pixel calibration pipeline.
package ccdcal_pkg;

   localparam int QBITS = 32;

   localparam logic [2:0] REG_FLAT_THRESHOLD = 3'd0;
   localparam logic [2:0] REG_EXPOSURE_TIME  = 3'd1;
   localparam logic [2:0] REG_BIAS_OFFSET    = 3'd2;
   localparam logic [2:0] REG_ORIENTATION    = 3'd3;
   localparam logic [2:0] REG_NUM_ROWS       = 3'd4;
   localparam logic [2:0] REG_NUM_COLS       = 3'd5;
   localparam logic [2:0] REG_WEIGHT_VALUE   = 3'd6;

   typedef struct packed {
      logic        neg;
      logic        over;
      logic        masked;
      logic [31:0] weight;
      logic [23:0] addr;
   } side_type;

endpackage

[rtl/core/ccdcal_divider.sv]
// Pipelined restoring divider, one quotient bit per stage, carrying sideband data.
module ccdcal_divider (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  logic [63:0]            in_dividend,
   input  logic [31:0]            in_divisor,
   input  ccdcal_pkg::side_type   in_side,
   output logic                   out_valid,
   output logic [31:0]            out_quotient,
   output ccdcal_pkg::side_type   out_side
);
   import ccdcal_pkg::*;

   logic                 valid_st [QBITS+1];
   logic [31:0]          rem_st   [QBITS+1];
   logic [31:0]          low_st   [QBITS+1];
   logic [31:0]          div_st   [QBITS+1];
   side_type             side_st  [QBITS+1];

   // The upper half is already below the divisor unless the item overflows.
   assign valid_st[0] = in_valid;
   assign rem_st[0]   = in_dividend[63:32];
   assign low_st[0]   = in_dividend[31:0];
   assign div_st[0]   = in_divisor;
   assign side_st[0]  = in_side;

   genvar s;
   generate
      for (s = 0; s < QBITS; s++) begin : g_stage
         logic [32:0] trial;
         logic        fits;
         logic        valid_in;
         logic [31:0] rem_in;
         logic [31:0] low_in;
         always_comb begin
            trial    = {rem_st[s], low_st[s][31]};
            fits     = trial >= {1'b0, div_st[s]};
            valid_in = valid_st[s];
            rem_in   = fits ? 32'(trial - {1'b0, div_st[s]}) : trial[31:0];
            low_in   = {low_st[s][30:0], fits};
         end
         logic        valid_ff;
         logic [31:0] rem_ff, low_ff, div_ff;
         side_type    side_ff;
         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff <= 1'b0;
            end else begin
               valid_ff <= valid_in;
            end
            rem_ff  <= rem_in;
            low_ff  <= low_in;
            div_ff  <= div_st[s];
            side_ff <= side_st[s];
         end
         assign valid_st[s+1] = valid_ff;
         assign rem_st[s+1]   = rem_ff;
         assign low_st[s+1]   = low_ff;
         assign div_st[s+1]   = div_ff;
         assign side_st[s+1]  = side_ff;
      end
   endgenerate

   assign out_valid    = valid_st[QBITS];
   assign out_quotient = low_st[QBITS];
   assign out_side     = side_st[QBITS];
endmodule

[rtl/core/ccd_pixel_calibrate_rotate.sv]
// Top level of the CCD bias and flat-field calibration with output rotation.
//
// Usage: a pixel is taken on any clock edge with req_start high; busy is
// always low, so one pixel may be issued every cycle. Each pixel yields one
// result, shown on the rsp_ ports for one cycle with rsp_valid high.
// The pipeline holds 36 register stages, the first loaded at the accepting
// edge: three stages form the products, numerator and rounded dividend, 32
// stages of a restoring divider each settle one quotient bit, and a last
// stage saturates and registers the outputs. Throughput is one pixel per
// cycle.
// Registers are written through csr_ (valid/ready, always ready) and must
// only change while no pixel is in flight.
// Synchronous reset empties the pipeline and loads the register defaults.
// The receiver cannot stall; results are never held back.
module ccd_pixel_calibrate_rotate #(
   parameter int MAX_ROWS = 4096,
   parameter int MAX_COLS = 4096
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_start,
   output logic               busy,
   input  logic [15:0]        req_raw_sample,
   input  logic [15:0]        req_bias_sample,
   input  logic [15:0]        req_flat_sample,
   input  logic [15:0]        req_dither_fraction,
   input  logic [11:0]        req_row_index,
   input  logic [11:0]        req_col_index,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_calibrated_value,
   output logic [31:0]        rsp_weight,
   output logic [23:0]        rsp_dest_address,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import ccdcal_pkg::*;

   logic [15:0] thr_ff, exp_ff;
   logic [16:0] boff_ff;
   logic        orient_ff;
   logic [12:0] nrows_ff, ncols_ff;
   logic [31:0] wval_ff;

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff    <= 16'd0;
         exp_ff    <= 16'd16;
         boff_ff   <= 17'd0;
         orient_ff <= 1'b0;
         nrows_ff  <= 13'd4096;
         ncols_ff  <= 13'd4096;
         wval_ff   <= 32'd65536;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FLAT_THRESHOLD: thr_ff    <= csr_data[15:0];
            REG_EXPOSURE_TIME:  exp_ff    <= csr_data[15:0];
            REG_BIAS_OFFSET:    boff_ff   <= csr_data[16:0];
            REG_ORIENTATION:    orient_ff <= csr_data[0];
            REG_NUM_ROWS:       nrows_ff  <= csr_data[12:0];
            REG_NUM_COLS:       ncols_ff  <= csr_data[12:0];
            REG_WEIGHT_VALUE:   wval_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // Stage 1: products and address terms.
   logic [15:0] e_eff;
   logic [12:0] nr, nc;
   logic [23:0] colterm;
   logic        s1_valid_ff;
   logic [31:0] s1_be_ff, s1_d_ff, s1_w_ff;
   logic [15:0] s1_raw_ff, s1_dith_ff;
   logic [16:0] s1_boff_ff;
   logic        s1_mask_ff;
   logic [23:0] s1_prod_ff, s1_base_ff;

   always_comb begin
      e_eff = (exp_ff == 16'd0) ? 16'd1 : exp_ff;
      nr = (32'(nrows_ff) > 32'(MAX_ROWS)) ? 13'(MAX_ROWS) : nrows_ff;
      nc = (32'(ncols_ff) > 32'(MAX_COLS)) ? 13'(MAX_COLS) : ncols_ff;
      colterm = orient_ff ? 24'(24'(nc) - 24'd1 - 24'(req_col_index))
                          : 24'(req_col_index);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_start;
      end
      s1_be_ff   <= req_bias_sample * e_eff;
      s1_d_ff    <= req_flat_sample * e_eff;
      s1_raw_ff  <= req_raw_sample;
      s1_dith_ff <= req_dither_fraction;
      s1_boff_ff <= boff_ff;
      s1_mask_ff <= req_flat_sample <= thr_ff;
      s1_w_ff    <= wval_ff;
      s1_prod_ff <= 24'(24'(nr) * colterm);
      s1_base_ff <= orient_ff ? 24'(req_row_index)
                              : 24'(24'(nr) - 24'd1 - 24'(req_row_index));
   end

   // Stage 2: signed numerator in Q.16 and its magnitude.
   logic signed [47:0] num;
   logic               s2_valid_ff, s2_neg_ff, s2_mask_ff;
   logic [46:0]        s2_mag_ff;
   logic [31:0]        s2_d_ff, s2_w_ff;
   logic [23:0]        s2_addr_ff;

   always_comb begin
      num = $signed({16'd0, s1_raw_ff, 16'd0}) + $signed({32'd0, s1_dith_ff})
          - $signed({4'd0, s1_be_ff, 12'd0})
          - $signed({{15{s1_boff_ff[16]}}, s1_boff_ff, 16'd0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s1_valid_ff;
      end
      s2_neg_ff  <= num[47];
      s2_mag_ff  <= num[47] ? 47'(-num) : num[46:0];
      s2_d_ff    <= s1_d_ff;
      s2_w_ff    <= s1_w_ff;
      s2_mask_ff <= s1_mask_ff;
      s2_addr_ff <= 24'(s1_base_ff + s1_prod_ff);
   end

   // Stage 3: dividend with the half-divisor rounding term, overflow check.
   logic [63:0] dvd;
   logic        s3_valid_ff;
   logic [63:0] s3_dvd_ff;
   logic [31:0] s3_d_ff;
   side_type    s3_side_ff;
   logic        ovf;

   always_comb begin
      dvd = 64'({s2_mag_ff, 18'd0}) + 64'(s2_d_ff >> 1);
      ovf = dvd[63:32] >= s2_d_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s2_valid_ff;
      end
      // An overflowing dividend is forced to zero so the divider stays in range.
      s3_dvd_ff          <= ovf ? 64'd0 : dvd;
      s3_d_ff            <= s2_d_ff;
      s3_side_ff.neg     <= s2_neg_ff;
      s3_side_ff.over    <= ovf;
      s3_side_ff.masked  <= s2_mask_ff;
      s3_side_ff.weight  <= s2_w_ff;
      s3_side_ff.addr    <= s2_addr_ff;
   end

   logic        dv_valid;
   logic [31:0] dv_q;
   side_type    dv_side;

   ccdcal_divider u_div (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (s3_valid_ff),
      .in_dividend  (s3_dvd_ff),
      .in_divisor   (s3_d_ff),
      .in_side      (s3_side_ff),
      .out_valid    (dv_valid),
      .out_quotient (dv_q),
      .out_side     (dv_side)
   );

   // Final stage: saturate, apply sign and mask.
   logic [31:0] value_in;
   logic        valid_ff;
   logic [31:0] value_ff, weight_ff;
   logic [23:0] addr_ff;

   always_comb begin
      if (dv_side.masked) begin
         value_in = 32'd0;
      end else if (dv_side.neg) begin
         value_in = (dv_side.over || dv_q > 32'h8000_0000) ? 32'h8000_0000
                                                           : 32'(-dv_q);
      end else begin
         value_in = (dv_side.over || dv_q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : dv_q;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= dv_valid;
      end
      value_ff  <= value_in;
      weight_ff <= dv_side.masked ? 32'd0 : dv_side.weight;
      addr_ff   <= dv_side.addr;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_calibrated_value = $signed(value_ff);
   assign rsp_weight           = weight_ff;
   assign rsp_dest_address     = addr_ff;
endmodule
